### design/htbp_pkg.sv
// Shared constants and helpers for the Huffman table bit packer.
`timescale 1ns / 1ps
`default_nettype none

package htbp_pkg;

	localparam int DEF_ALPHABET_SIZE = 256;
	localparam int DEF_MAX_CODE_LEN  = 32;

	// fixed field widths of the stream payloads
	localparam int SYMBOL_W   = 8;
	localparam int CODE_W     = 32;
	localparam int CODE_LEN_W = 6;
	localparam int WORD_W     = 32;
	localparam int CFG_W      = 6;
	localparam int BUF_W      = 64;
	localparam int COUNT_W    = 7;
	localparam int IN_TDATA_W = 48;

	localparam logic [CFG_W-1:0] RESET_WORD_WIDTH = CFG_W'(32);

	// one emitted word per cycle while the output is not stalled, at most this many per encode
	localparam int MAX_WORDS = 32;
	localparam int WCNT_W    = 5;

	localparam logic IN_KIND_ENCODE = 1'b0;
	localparam logic IN_KIND_LOAD   = 1'b1;

	// low n bits set, n in 0..32
	function automatic logic [WORD_W-1:0] low_mask(input logic [CFG_W-1:0] n);
		logic [WORD_W-1:0] m;
		m = ~({WORD_W{1'b1}} << n);
		return m;
	endfunction

endpackage

`default_nettype wire

### design/htbp_code_table.sv
// Code table memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module htbp_code_table
	import htbp_pkg::*;
#(
	parameter int DEPTH  = DEF_ALPHABET_SIZE,
	parameter int ADDR_W = 8,
	parameter int BITS_W = DEF_MAX_CODE_LEN,
	parameter int LEN_W  = 6
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr_en,
	input  wire  [ADDR_W-1:0] wr_addr,
	input  wire  [BITS_W-1:0] wr_bits,
	input  wire  [LEN_W-1:0]  wr_len,
	input  wire               rd_en,
	input  wire  [ADDR_W-1:0] rd_addr,
	output logic [BITS_W-1:0] rd_bits,
	output logic [LEN_W-1:0]  rd_len
);

	logic [BITS_W+LEN_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]        valid_q;
	logic [BITS_W+LEN_W-1:0] rd_data_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_bits, wr_len};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// valid bits stand in for clearing the table at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_bits = rd_valid_q ? rd_data_q[BITS_W+LEN_W-1:LEN_W] : '0;
	assign rd_len  = rd_valid_q ? rd_data_q[LEN_W-1:0] : '0;

endmodule

`default_nettype wire

### design/huffman_table_bit_packer.sv
// Top level: code table load, code lookup and word packing sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Huffman table bit packer. Load beats (tuser = 1) write one code table entry;
// the table reads as all-empty after reset. Encode beats (tuser = 0) look up
// the symbol's code, append it root-first to a 64-bit LSB-first bit buffer,
// then emit words of word_width bits while more than word_width bits are
// buffered, tlast on the final word of that beat. An encode goes from accept
// through the lookup state, then the drain state, which emits its words (at
// most 32), before the next beat is accepted. The drain loop runs one word per
// cycle through a single shifter while the output is not stalled; output
// stalls hold it. s_tready is low while an encode is in progress. Leftover
// bits stay buffered; there is no flush.
module huffman_table_bit_packer
	import htbp_pkg::*;
#(
	parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
	parameter int MAX_CODE_LEN  = DEF_MAX_CODE_LEN
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// config: word_width
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_W-1:0]      cfg_data,
	// s_tdata: symbol[7:0], code_bits[39:8], code_length[45:40], zero[47:46]
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [IN_TDATA_W-1:0] s_tdata,
	// s_tuser: kind
	input  wire                   s_tuser,
	// m_tdata: packed_word[31:0]
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [WORD_W-1:0]     m_tdata,
	output logic                  m_tlast
);

	localparam int TABLE_DEPTH = (ALPHABET_SIZE < 256) ? ALPHABET_SIZE : 256;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LEN_W       = $clog2(MAX_CODE_LEN + 1);
	localparam int RANGE_W     = 17;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_DRAIN  = 3'b100
	} state_t;

	state_t                state_q;
	logic [BUF_W-1:0]      buffer_q;
	logic [COUNT_W-1:0]    count_q;
	logic [WCNT_W-1:0]     nword_q;
	logic [CFG_W-1:0]      width_q;
	logic                  sym_ok_q;
	logic [WORD_W-1:0]     word_q;
	logic                  last_q;
	logic                  out_valid_q;

	logic [SYMBOL_W-1:0]   in_symbol;
	logic [CODE_W-1:0]     in_code_bits;
	logic [CODE_LEN_W-1:0] in_code_length;
	logic                  in_accept;
	logic                  sym_ok;
	logic [CODE_LEN_W-1:0] len_sat;
	logic [WORD_W-1:0]     len_keep;
	logic [MAX_CODE_LEN-1:0] load_bits;
	logic                  tbl_wr_en;
	logic                  tbl_rd_en;
	logic [MAX_CODE_LEN-1:0] tbl_bits;
	logic [LEN_W-1:0]      tbl_len;

	logic [CFG_W-1:0]      eff_w;
	logic [COUNT_W-1:0]    eff_w_ext;
	logic                  out_free;
	logic                  have_word;
	logic                  word_load;
	logic [COUNT_W-1:0]    count_next;
	logic                  more_words;
	logic [BUF_W-1:0]      append_bits;

	assign in_symbol      = s_tdata[SYMBOL_W-1:0];
	assign in_code_bits   = s_tdata[SYMBOL_W+CODE_W-1:SYMBOL_W];
	assign in_code_length = s_tdata[SYMBOL_W+CODE_W+CODE_LEN_W-1:SYMBOL_W+CODE_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign sym_ok = (RANGE_W'(in_symbol) < RANGE_W'(ALPHABET_SIZE));

	// saturate length and clear bits above it before storing
	assign len_sat = (in_code_length > CODE_LEN_W'(MAX_CODE_LEN)) ?
		CODE_LEN_W'(MAX_CODE_LEN) : in_code_length;
	assign len_keep  = low_mask(len_sat);
	assign load_bits = in_code_bits[MAX_CODE_LEN-1:0] & len_keep[MAX_CODE_LEN-1:0];

	assign tbl_wr_en = in_accept && (s_tuser == IN_KIND_LOAD) && sym_ok;
	assign tbl_rd_en = in_accept && (s_tuser == IN_KIND_ENCODE);

	htbp_code_table #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W),
		.BITS_W (MAX_CODE_LEN),
		.LEN_W  (LEN_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr_en),
		.wr_addr (in_symbol[ADDR_W-1:0]),
		.wr_bits (load_bits),
		.wr_len  (len_sat[LEN_W-1:0]),
		.rd_en   (tbl_rd_en),
		.rd_addr (in_symbol[ADDR_W-1:0]),
		.rd_bits (tbl_bits),
		.rd_len  (tbl_len)
	);

	// width 0 acts as 1, above 32 as 32
	always_comb begin
		if (width_q == '0) begin
			eff_w = CFG_W'(1);
		end else if (width_q > CFG_W'(WORD_W)) begin
			eff_w = CFG_W'(WORD_W);
		end else begin
			eff_w = width_q;
		end
	end

	assign eff_w_ext   = COUNT_W'(eff_w);
	assign out_free    = !out_valid_q || m_tready;
	assign have_word   = (count_q > eff_w_ext);
	assign word_load   = (state_q == ST_DRAIN) && have_word && out_free;
	assign count_next  = count_q - eff_w_ext;
	assign more_words  = (count_next > eff_w_ext) &&
		(nword_q != WCNT_W'(MAX_WORDS - 1));
	assign append_bits = BUF_W'(tbl_bits) << count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			buffer_q    <= '0;
			count_q     <= '0;
			nword_q     <= '0;
			width_q     <= RESET_WORD_WIDTH;
			sym_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				width_q <= cfg_data;
			end
			out_valid_q <= word_load || (out_valid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (tbl_rd_en) begin
						sym_ok_q <= sym_ok;
						state_q  <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					// count stays at or below 32 between beats
					if (sym_ok_q && (tbl_len != '0)) begin
						buffer_q <= buffer_q | append_bits;
						count_q  <= count_q + COUNT_W'(tbl_len);
					end
					nword_q <= '0;
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!have_word) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						buffer_q    <= buffer_q >> eff_w;
						count_q     <= count_next;
						nword_q     <= nword_q + WCNT_W'(1);
						if (!more_words) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (word_load) begin
			word_q <= buffer_q[WORD_W-1:0] & low_mask(eff_w);
			last_q <= !more_words;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = word_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire
